// File: design/crv_pkg.sv
`default_nettype none
package crv_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int EXT_BITS    = SAMPLE_BITS + 4;
  localparam int COMB_DEPTH  = 4096;
  localparam int AP_DEPTH    = 2048;
  localparam int NUM_COMBS   = 4;
  localparam int NUM_APS     = 2;
  localparam int COMB_AW     = $clog2(COMB_DEPTH);
  localparam int AP_AW       = $clog2(AP_DEPTH);

  localparam int COMB_LEN_BITS  = 12;
  localparam int AP_LEN_BITS    = 11;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 3;

  localparam int COMB_LEN_MAX = (COMB_DEPTH - 1 < 4095) ? COMB_DEPTH - 1 : 4095;
  localparam int AP_LEN_MAX   = (AP_DEPTH - 1 < 2047) ? AP_DEPTH - 1 : 2047;

  localparam logic [COMB_LEN_BITS-1:0] COMB_LEN_RST [NUM_COMBS] =
    '{12'd1116, 12'd1277, 12'd1422, 12'd1557};
  localparam logic [AP_LEN_BITS-1:0] AP_LEN_RST [NUM_APS] = '{11'd556, 11'd341};

  // Q0.16 coefficients.
  localparam logic [16:0] K_IN_GAIN  = 17'd11796;
  localparam logic [16:0] K_FEEDBACK = 17'd55050;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COMB_A = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMB_B = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMB_C = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMB_D = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AP_A   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AP_B   = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [EXT_BITS-1:0]    wide_t;

  typedef struct packed {
    logic load;
    logic damp;
    logic fb;
    logic comb_wr;
    logic ap_a;
    logic ap_b;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic wide_t widen(sample_t a);
    return EXT_BITS'(a);
  endfunction

  function automatic sample_t sat(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = {{(EXT_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = {{(EXT_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Product with a Q0.16 coefficient, rounded half up.
  function automatic wide_t qmul(sample_t a, logic [16:0] k);
    logic signed [SAMPLE_BITS+17:0] prod;
    prod = $signed({{18{a[SAMPLE_BITS-1]}}, a}) * $signed({{(SAMPLE_BITS+1){1'b0}}, k});
    prod = prod + (SAMPLE_BITS+18)'(32768);
    return EXT_BITS'(prod >>> 16);
  endfunction

  function automatic logic [COMB_AW-1:0] comb_eff(logic [COMB_LEN_BITS-1:0] v);
    if (v == '0) begin
      return COMB_AW'(1);
    end else if (32'(v) > COMB_LEN_MAX) begin
      return COMB_AW'(COMB_LEN_MAX);
    end
    return COMB_AW'(v);
  endfunction

  function automatic logic [AP_AW-1:0] ap_eff(logic [AP_LEN_BITS-1:0] v);
    if (v == '0) begin
      return AP_AW'(1);
    end else if (32'(v) > AP_LEN_MAX) begin
      return AP_AW'(AP_LEN_MAX);
    end
    return AP_AW'(v);
  endfunction

endpackage
`default_nettype wire

// File: design/crv_ram.sv
`default_nettype none
module crv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: design/crv_ctrl.sv
`default_nettype none
module crv_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire crv_pkg::stat_t stat,
  output      crv_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DAMP = 6'b000010,
    ST_FB   = 6'b000100,
    ST_CWR  = 6'b001000,
    ST_APA  = 6'b010000,
    ST_APB  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DAMP;
        end
      end
      ST_DAMP: begin
        cmd.damp  = 1'b1;
        state_nxt = ST_FB;
      end
      ST_FB: begin
        cmd.fb    = 1'b1;
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        cmd.comb_wr = 1'b1;
        state_nxt   = ST_APA;
      end
      ST_APA: begin
        cmd.ap_a  = 1'b1;
        state_nxt = ST_APB;
      end
      ST_APB: begin
        // The last section writes its line only once the output register can take the beat.
        if (stat.out_free) begin
          cmd.ap_b  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule
`default_nettype wire

// File: design/crv_datapath.sv
`default_nettype none
module crv_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire crv_pkg::cmd_t                        cmd,
  output      crv_pkg::stat_t                       stat,
  input  wire crv_pkg::sample_t                     in_dry_sample,
  input  wire logic                                 cfg_we,
  input  wire logic [crv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [crv_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                 out_ready,
  output      logic                                 out_valid,
  output      crv_pkg::sample_t                     out_wet_sample
);

  localparam int NC = crv_pkg::NUM_COMBS;
  localparam int NA = crv_pkg::NUM_APS;

  crv_pkg::sample_t s_r;
  crv_pkg::sample_t damp_r [NC];
  crv_pkg::sample_t fb_r   [NC];
  crv_pkg::sample_t cy_r   [NC];
  crv_pkg::sample_t apy_r  [NA];
  crv_pkg::sample_t sum_r;
  crv_pkg::sample_t oa_r;
  crv_pkg::sample_t out_data_r;
  logic             out_valid_r;

  logic [crv_pkg::COMB_AW-1:0] cpos_r [NC];
  logic [crv_pkg::COMB_AW-1:0] clen_r [NC];
  logic                        cwrap_r [NC];
  logic [crv_pkg::AP_AW-1:0]   apos_r [NA];
  logic [crv_pkg::AP_AW-1:0]   alen_r [NA];
  logic                        awrap_r [NA];

  crv_pkg::sample_t crdata   [NC];
  crv_pkg::sample_t cwdata   [NC];
  crv_pkg::sample_t cy_nxt   [NC];
  crv_pkg::sample_t damp_nxt [NC];
  crv_pkg::sample_t ardata   [NA];
  crv_pkg::sample_t awdata   [NA];
  crv_pkg::sample_t apy_nxt  [NA];
  crv_pkg::sample_t sum_nxt;
  crv_pkg::sample_t oa_nxt;
  crv_pkg::sample_t ob_nxt;
  logic [crv_pkg::COMB_AW-1:0] cpos_inc [NC];
  logic [crv_pkg::AP_AW-1:0]   apos_inc [NA];
  logic                        cfg_hit;

  for (genvar g = 0; g < NC; g++) begin : g_comb
    crv_ram #(
      .WIDTH(crv_pkg::SAMPLE_BITS),
      .DEPTH(crv_pkg::COMB_DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (cmd.comb_wr),
      .waddr   (cpos_r[g]),
      .wdata   (cwdata[g]),
      .re      (cmd.load),
      .raddr   (cpos_r[g]),
      .rd_data (crdata[g])
    );
  end

  for (genvar g = 0; g < NA; g++) begin : g_ap
    crv_ram #(
      .WIDTH(crv_pkg::SAMPLE_BITS),
      .DEPTH(crv_pkg::AP_DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      ((g == 0) ? cmd.ap_a : cmd.ap_b),
      .waddr   (apos_r[g]),
      .wdata   (awdata[g]),
      .re      (cmd.load),
      .raddr   (apos_r[g]),
      .rd_data (ardata[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      // Positions run upward from zero, so an entry has been written once its line has wrapped.
      cy_nxt[i]   = cwrap_r[i] ? crdata[i] : '0;
      damp_nxt[i] = crv_pkg::sat(((crv_pkg::widen(cy_nxt[i]) <<< 1)
                    + crv_pkg::widen(cy_nxt[i]) + crv_pkg::widen(damp_r[i])
                    + crv_pkg::wide_t'(2)) >>> 2);
      cwdata[i]   = crv_pkg::sat(crv_pkg::widen(s_r) + crv_pkg::widen(fb_r[i]));
      cpos_inc[i] = cpos_r[i] + 1'b1;
    end
    for (int j = 0; j < NA; j++) begin
      apy_nxt[j]  = awrap_r[j] ? ardata[j] : '0;
      apos_inc[j] = apos_r[j] + 1'b1;
    end
    sum_nxt = crv_pkg::sat(crv_pkg::widen(cy_r[0]) + crv_pkg::widen(cy_r[1])
              + crv_pkg::widen(cy_r[2]) + crv_pkg::widen(cy_r[3]));
    oa_nxt  = crv_pkg::sat(crv_pkg::widen(apy_r[0]) - crv_pkg::widen(sum_r));
    ob_nxt  = crv_pkg::sat(crv_pkg::widen(apy_r[1]) - crv_pkg::widen(oa_r));
    awdata[0] = crv_pkg::sat(crv_pkg::widen(sum_r)
                + ((crv_pkg::widen(apy_r[0]) + crv_pkg::wide_t'(1)) >>> 1));
    awdata[1] = crv_pkg::sat(crv_pkg::widen(oa_r)
                + ((crv_pkg::widen(apy_r[1]) + crv_pkg::wide_t'(1)) >>> 1));
  end

  assign cfg_hit = cfg_we && (cfg_index <= crv_pkg::REG_AP_B);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r <= crv_pkg::sat(crv_pkg::qmul(in_dry_sample, crv_pkg::K_IN_GAIN));
    end
    if (cmd.damp) begin
      cy_r  <= cy_nxt;
      apy_r <= apy_nxt;
    end
    if (cmd.fb) begin
      for (int i = 0; i < NC; i++) begin
        fb_r[i] <= crv_pkg::sat(crv_pkg::qmul(damp_r[i], crv_pkg::K_FEEDBACK));
      end
    end
    if (cmd.comb_wr) begin
      sum_r <= sum_nxt;
    end
    if (cmd.ap_a) begin
      oa_r <= oa_nxt;
    end
    if (cmd.ap_b) begin
      out_data_r <= ob_nxt;
    end
  end

  // Line state: lengths, positions, wrap flags and damping memories.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        clen_r[i]  <= crv_pkg::comb_eff(crv_pkg::COMB_LEN_RST[i]);
        cpos_r[i]  <= '0;
        cwrap_r[i] <= 1'b0;
        damp_r[i]  <= '0;
      end
      for (int j = 0; j < NA; j++) begin
        alen_r[j]  <= crv_pkg::ap_eff(crv_pkg::AP_LEN_RST[j]);
        apos_r[j]  <= '0;
        awrap_r[j] <= 1'b0;
      end
    end else if (cfg_hit) begin
      case (cfg_index)
        crv_pkg::REG_COMB_A: clen_r[0] <= crv_pkg::comb_eff(cfg_data);
        crv_pkg::REG_COMB_B: clen_r[1] <= crv_pkg::comb_eff(cfg_data);
        crv_pkg::REG_COMB_C: clen_r[2] <= crv_pkg::comb_eff(cfg_data);
        crv_pkg::REG_COMB_D: clen_r[3] <= crv_pkg::comb_eff(cfg_data);
        crv_pkg::REG_AP_A:   alen_r[0] <= crv_pkg::ap_eff(cfg_data[crv_pkg::AP_LEN_BITS-1:0]);
        crv_pkg::REG_AP_B:   alen_r[1] <= crv_pkg::ap_eff(cfg_data[crv_pkg::AP_LEN_BITS-1:0]);
        default: ;
      endcase
      // Any length write empties every line: clearing the wrap flags makes all entries read zero.
      for (int i = 0; i < NC; i++) begin
        cpos_r[i]  <= '0;
        cwrap_r[i] <= 1'b0;
        damp_r[i]  <= '0;
      end
      for (int j = 0; j < NA; j++) begin
        apos_r[j]  <= '0;
        awrap_r[j] <= 1'b0;
      end
    end else begin
      if (cmd.damp) begin
        damp_r <= damp_nxt;
      end
      if (cmd.comb_wr) begin
        for (int i = 0; i < NC; i++) begin
          if (cpos_inc[i] >= clen_r[i]) begin
            cpos_r[i]  <= '0;
            cwrap_r[i] <= 1'b1;
          end else begin
            cpos_r[i] <= cpos_inc[i];
          end
        end
      end
      if (cmd.ap_a) begin
        if (apos_inc[0] >= alen_r[0]) begin
          apos_r[0]  <= '0;
          awrap_r[0] <= 1'b1;
        end else begin
          apos_r[0] <= apos_inc[0];
        end
      end
      if (cmd.ap_b) begin
        if (apos_inc[1] >= alen_r[1]) begin
          apos_r[1]  <= '0;
          awrap_r[1] <= 1'b1;
        end else begin
          apos_r[1] <= apos_inc[1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ap_b) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_wet_sample = out_data_r;

endmodule
`default_nettype wire

// File: design/comb_allpass_reverb.sv
// Each accepted sample is stepped by the sequencer through read, damping, feedback, comb
// write and the two allpass sections in turn; the result beat is registered by the last
// allpass step, and no new sample is taken until that step is done.
// A result still held in the output register stalls only the last allpass step.
// Reset (rst_n low, synchronous) restores the default lengths and empties all lines
// at once; there is no clearing pass, and a length write empties them the same way.
`default_nettype none
module comb_allpass_reverb (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire crv_pkg::sample_t                    in_dry_sample,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      crv_pkg::sample_t                    out_wet_sample,
  input  wire logic                                cfg_we,
  input  wire logic [crv_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [crv_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  crv_pkg::cmd_t  cmd;
  crv_pkg::stat_t stat;

  crv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crv_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_dry_sample  (in_dry_sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_wet_sample (out_wet_sample)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a beat");

  a_min_item_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##4 !in_ready)
    else $error("sample sequence ended too early");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in flight");

endmodule
`default_nettype wire
